// ----- hdl/fssa_pkg.sv -----
// Package for the flash sector status allocator: types, codes, constants.
// No dependencies.
package fssa_pkg;
  localparam int MAX_SECTORS = 4096;
  localparam int SW = $clog2(MAX_SECTORS);
  localparam int CW = 13;
  localparam int TW = 13;
  localparam logic [TW-1:0] TALLY_MAX = '1;
  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_SCAN = 2'd0, MODE_ALLOC = 2'd1, MODE_REL = 2'd2, MODE_BAD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0, ST_TODELETE = 3'd1, ST_ACTIVE = 3'd2,
    ST_DELETED = 3'd3, ST_DATA = 3'd4, ST_UNKNOWN = 3'd5
  } sstat_t;

  typedef enum logic [2:0] {
    RS_OK = 3'd0, RS_NOFREE = 3'd1, RS_BADIDX = 3'd2,
    RS_ILLEGAL = 3'd3, RS_UNKNOWN = 3'd4
  } rstat_t;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_DELETED = 3'd1;
  localparam logic [2:0] CFG_DATA = 3'd2;
  localparam logic [2:0] CFG_TODEL = 3'd3;
  localparam logic [2:0] CFG_COUNT = 3'd4;

  // classified command passed from front to back
  typedef struct packed {
    mode_t        mode;
    logic         bad_idx;
    logic         first;     // scan of sector 1
    logic [SW-1:0] sector;
    sstat_t       cls;       // scan classification
    logic         as_head;
  } cmd_t;
endpackage

// ----- hdl/fssa_front.sv -----
// Front: accepts beats, checks the index and classifies header words.
// Depends on fssa_pkg.
module fssa_front import fssa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [1:0]    mode,
  input  logic [11:0]   sector,
  input  logic [31:0]   header_word,
  input  logic          as_head,
  input  logic [31:0]   m_active,
  input  logic [31:0]   m_deleted,
  input  logic [31:0]   m_data,
  input  logic [31:0]   m_todel,
  input  logic [SW:0]   eff_n,
  output logic          q_valid,
  input  logic          q_pop,
  output cmd_t          q_cmd
);
  // two-entry queue
  cmd_t q [2];
  logic [1:0] cnt;
  logic rd, wr;
  cmd_t c;
  logic push;

  always_comb begin
    c.mode = mode_t'(mode);
    c.sector = sector[SW-1:0];
    c.as_head = as_head;
    c.bad_idx = (sector == '0) || ({1'b0, sector} >= eff_n);
    c.first = (sector == 12'd1);
    if (header_word == ERASED_WORD) c.cls = ST_CLEAR;
    else if (header_word == m_todel) c.cls = ST_TODELETE;
    else if (header_word == m_active) c.cls = ST_ACTIVE;
    else if (header_word == m_deleted) c.cls = ST_DELETED;
    else if (header_word == m_data) c.cls = ST_DATA;
    else c.cls = ST_UNKNOWN;
  end

  assign stall = (cnt == 2'd2);
  assign push = valid && !stall;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0;
    end else begin
      if (push) begin
        q[wr] <= c;
        wr <= ~wr;
      end
      if (q_pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ----- hdl/fssa_back.sv -----
// Back: status table memory, cursor walk, tallies and result register.
// Depends on fssa_pkg.
module fssa_back import fssa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  cmd_t            q_cmd,
  input  logic [SW:0]     eff_n,
  output logic            valid,
  input  logic            stall,
  output logic [2:0]      status,
  output logic [11:0]     granted_sector,
  output logic            erase_needed,
  output logic [TW-1:0]   clear_count,
  output logic [TW-1:0]   todelete_count,
  output logic [TW-1:0]   unknown_count,
  output logic [TW-1:0]   active_files,
  output logic [TW-1:0]   used_files,
  output logic [TW-1:0]   free_sectors
);
  typedef enum logic [2:0] {
    S_WIPE, S_IDLE, S_READ, S_EVAL, S_WALK, S_WCHK, S_OUT
  } state_t;
  state_t state;

  logic [2:0] mem [MAX_SECTORS];
  logic [2:0] rdata;
  logic [SW-1:0] raddr, waddr;
  logic we;
  logic [2:0] wdata;

  // clearing pass pointer
  logic [SW:0] wptr;
  logic wipe_eval;   // clearing pass started by a scan of sector 1
  cmd_t cmd;
  logic [SW-1:0] cursor;
  logic [SW:0] tries;
  logic [TW-1:0] t_clr, t_td, t_unk, t_act, t_used, t_free;

  // read-latency tracking for the walk
  logic rd_done;
  logic rdata_ok;

  function automatic logic [TW-1:0] inc(input logic [TW-1:0] t);
    return (t == TALLY_MAX) ? t : t + 1'b1;
  endfunction
  function automatic logic [TW-1:0] dec(input logic [TW-1:0] t);
    return (t == '0) ? t : t - 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [SW-1:0] nxt;
  always_comb begin
    nxt = cursor + 1'b1;
    if ({1'b0, nxt} >= eff_n || nxt == '0) nxt = {{(SW-1){1'b0}}, 1'b1};
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE; wptr <= '0; valid <= 1'b0; cursor <= '0;
      t_clr <= '0; t_td <= '0; t_unk <= '0; t_act <= '0; t_used <= '0; t_free <= '0;
      we <= 1'b0; wipe_eval <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        S_WIPE: begin
          // clearing pass over the whole table
          we <= 1'b1; waddr <= wptr[SW-1:0]; wdata <= ST_CLEAR;
          wptr <= wptr + 1'b1;
          if (wptr == (SW+1)'(MAX_SECTORS - 1)) begin
            state <= wipe_eval ? S_EVAL : S_IDLE;
            wipe_eval <= 1'b0;
          end
        end
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd; raddr <= q_cmd.sector;
          granted_sector <= '0; erase_needed <= 1'b0;
          unique case (q_cmd.mode)
            MODE_SCAN: begin
              if (q_cmd.bad_idx) begin status <= RS_BADIDX; state <= S_OUT; end
              else if (q_cmd.first) begin
                // wipe the table first, then record sector 1
                wptr <= '0; wipe_eval <= 1'b1; state <= S_WIPE;
                cursor <= '0; t_clr <= '0; t_td <= '0; t_unk <= '0;
                t_act <= '0; t_used <= '0;
                t_free <= TW'(eff_n - 1'b1);
              end else state <= S_EVAL;
            end
            MODE_REL: begin
              if (q_cmd.bad_idx) begin status <= RS_BADIDX; state <= S_OUT; end
              else state <= S_READ;
            end
            MODE_ALLOC: begin
              tries <= (eff_n > 1) ? eff_n - 1'b1 : '0;
              state <= S_WALK;
            end
            default: begin status <= RS_ILLEGAL; state <= S_OUT; end
          endcase
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (cmd.mode == MODE_SCAN) begin
            we <= 1'b1; waddr <= cmd.sector; wdata <= cmd.cls;
            status <= RS_OK;
            unique case (cmd.cls)
              ST_CLEAR: t_clr <= inc(t_clr);
              ST_TODELETE: begin t_td <= inc(t_td); cursor <= cmd.sector; end
              ST_ACTIVE: begin
                t_act <= inc(t_act); t_used <= inc(t_used);
                t_free <= dec(t_free); cursor <= cmd.sector;
              end
              ST_DELETED: begin
                t_used <= inc(t_used); t_free <= dec(t_free); cursor <= cmd.sector;
              end
              ST_DATA: begin t_free <= dec(t_free); cursor <= cmd.sector; end
              default: begin t_unk <= inc(t_unk); status <= RS_UNKNOWN; end
            endcase
            state <= S_OUT;
          end else begin
            if (rdata == ST_ACTIVE) begin
              we <= 1'b1; waddr <= cmd.sector; wdata <= ST_DELETED;
              t_act <= dec(t_act); status <= RS_OK;
            end else if (rdata == ST_DATA) begin
              we <= 1'b1; waddr <= cmd.sector; wdata <= ST_TODELETE;
              t_free <= inc(t_free); status <= RS_OK;
            end else status <= RS_ILLEGAL;
            state <= S_OUT;
          end
        end
        S_WALK: begin
          if (tries == '0) begin status <= RS_NOFREE; state <= S_OUT; end
          else begin
            cursor <= nxt; raddr <= nxt; tries <= tries - 1'b1;
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          // wait for the registered table read, then check
          if (rdata_ok) begin
            erase_needed <= (rdata == ST_TODELETE);
            granted_sector <= 12'(cursor);
            we <= 1'b1; waddr <= cursor;
            wdata <= cmd.as_head ? ST_ACTIVE : ST_DATA;
            if (cmd.as_head) begin t_act <= inc(t_act); t_used <= inc(t_used); end
            t_free <= dec(t_free); status <= RS_OK;
            state <= S_OUT;
          end else if (rd_done) state <= S_WALK;
        end
        S_OUT: begin
          valid <= 1'b1;
          if (valid && !stall) begin valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_done <= 1'b0;
    else rd_done <= (state == S_WCHK) && !rd_done ? 1'b1 : 1'b0;
  end
  assign rdata_ok = rd_done && (rdata == ST_CLEAR || rdata == ST_TODELETE);

  assign clear_count = t_clr;
  assign todelete_count = t_td;
  assign unknown_count = t_unk;
  assign active_files = t_act;
  assign used_files = t_used;
  assign free_sectors = t_free;
endmodule

// ----- hdl/flash_sector_status_allocator_unit.sv -----
// Top level of the flash sector status allocator: config registers,
// front classifier, command queue and back end. Depends on fssa_pkg.
//
// channel | handshake     | payload
// in      | valid / stall | mode, sector, header_word, as_head
// out     | out_valid / out_stall | status, granted_sector, erase_needed, tallies
// cfg     | cfg_we        | cfg_index, cfg_data
//
// Allocate walks the status table one sector at a time, as the table has only a
// single read port.
// After reset, and before a scan of sector 1 is recorded, a clearing pass over all
// 4096 entries sweeps the table; items queue in front meanwhile.
// Synchronous active-high reset. Either side may stall independently.
module flash_sector_status_allocator_unit import fssa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [1:0]    mode,
  input  logic [11:0]   sector,
  input  logic [31:0]   header_word,
  input  logic          as_head,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    status,
  output logic [11:0]   granted_sector,
  output logic          erase_needed,
  output logic [12:0]   clear_count,
  output logic [12:0]   todelete_count,
  output logic [12:0]   unknown_count,
  output logic [12:0]   active_files,
  output logic [12:0]   used_files,
  output logic [12:0]   free_sectors,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  logic [31:0] m_active, m_deleted, m_data, m_todel;
  logic [CW-1:0] scount;
  logic [SW:0] eff_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_active <= 32'd0; m_deleted <= 32'd1; m_data <= 32'd2; m_todel <= 32'd3;
      scount <= CW'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: m_active <= cfg_data;
        CFG_DELETED: m_deleted <= cfg_data;
        CFG_DATA: m_data <= cfg_data;
        CFG_TODEL: m_todel <= cfg_data;
        CFG_COUNT: scount <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // sector_count limited to the table depth
  assign eff_n = (scount > CW'(MAX_SECTORS)) ? (SW+1)'(MAX_SECTORS) : scount[SW:0];

  logic q_valid, q_pop;
  cmd_t q_cmd;

  fssa_front u_front (
    .clk, .rst, .valid, .stall, .mode, .sector, .header_word, .as_head,
    .m_active, .m_deleted, .m_data, .m_todel, .eff_n,
    .q_valid, .q_pop, .q_cmd
  );

  fssa_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .eff_n,
    .valid(out_valid), .stall(out_stall),
    .status, .granted_sector, .erase_needed,
    .clear_count, .todelete_count, .unknown_count,
    .active_files, .used_files, .free_sectors
  );
endmodule
